[src/ws2812_pixel_serializer_assert.svh]
// Assertion helpers for the pixel serializer. Every user module has clk and rst_n.
`ifndef WS2812_PIXEL_SERIALIZER_ASSERT_SVH
`define WS2812_PIXEL_SERIALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wsps_pkg.sv]
package wsps_pkg;

  localparam int DEF_PIXEL_DEPTH = 256;
  localparam int DEF_RESET_SLOTS = 48;

  localparam int PIXEL_W        = 24;
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_W          = 5;
  localparam int BYTE_W         = 8;
  localparam int INDEX_W        = 8;
  localparam int FUNC_W         = 2;
  localparam int LED_COUNT_W    = 9;
  localparam int LOW_DUTY_W     = 15;
  localparam int DUTY_W         = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SHOW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  localparam logic REG_LED_COUNT = 1'b0;
  localparam logic REG_LOW_DUTY  = 1'b1;

  // What the control side decided for one slot tick.
  typedef struct packed {
    logic             is_data;
    logic [BIT_W-1:0] bit_sel;
    logic             busy;
    logic             frame_end;
  } slot_t;

endpackage

[src/wsps_ram.sv]
module wsps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/wsps_ctrl.sv]
`include "ws2812_pixel_serializer_assert.svh"

module wsps_ctrl #(
  parameter int PIXEL_DEPTH = wsps_pkg::DEF_PIXEL_DEPTH,
  parameter int RESET_SLOTS = wsps_pkg::DEF_RESET_SLOTS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        acc_show,
  input  logic                                        acc_tick,
  input  logic [wsps_pkg::LED_COUNT_W-1:0]            led_count,
  output wsps_pkg::slot_t                             slot,
  output logic                                        rd_en,
  output logic [(PIXEL_DEPTH > 1 ? $clog2(PIXEL_DEPTH) : 1)-1:0] rd_addr
);

  localparam int CNT_LIMIT = (1 << wsps_pkg::LED_COUNT_W) - 1;
  localparam int MAX_CNT   = (PIXEL_DEPTH < CNT_LIMIT) ? PIXEL_DEPTH : CNT_LIMIT;
  localparam int PC_W      = $clog2(MAX_CNT + 1);
  localparam int CW        = (PC_W > wsps_pkg::LED_COUNT_W) ? PC_W : wsps_pkg::LED_COUNT_W;
  localparam int RC_W      = $clog2(RESET_SLOTS + 1);
  localparam int AW        = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
  localparam int BW        = wsps_pkg::BIT_W;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_PIXELS = 3'b010,
    PH_RESET  = 3'b100
  } phase_t;

  phase_t          ph_r, ph_nxt, ph_eff;
  logic [PC_W-1:0] pc_r, pc_nxt, pc_inc;
  logic [BW-1:0]   bc_r, bc_nxt;
  logic [RC_W-1:0] rc_r, rc_nxt;
  logic [CW-1:0]   cnt_ext, eff_cnt;

  // Pixel count clamped to what the store holds.
  assign cnt_ext = CW'(led_count);
  assign eff_cnt = (cnt_ext > CW'(MAX_CNT)) ? CW'(MAX_CNT) : cnt_ext;
  assign pc_inc  = pc_r + 1'b1;
  assign rd_addr = AW'(pc_r);

  always_comb begin
    ph_nxt = ph_r;
    pc_nxt = pc_r;
    bc_nxt = bc_r;
    rc_nxt = rc_r;
    ph_eff = ph_r;
    slot   = '0;
    rd_en  = 1'b0;
    if (acc_show) begin
      pc_nxt = '0;
      bc_nxt = '0;
      rc_nxt = '0;
      ph_nxt = (ph_r == PH_IDLE) ? PH_PIXELS : PH_IDLE;
    end else if (acc_tick) begin
      // A count lowered mid-frame ends the pixel part before this slot.
      if (ph_r == PH_PIXELS && CW'(pc_r) >= eff_cnt) begin
        ph_eff = PH_RESET;
      end
      case (ph_eff)
        PH_PIXELS: begin
          rd_en        = 1'b1;
          slot.is_data = 1'b1;
          slot.bit_sel = bc_r;
          if (bc_r == BW'(wsps_pkg::BITS_PER_PIXEL - 1)) begin
            bc_nxt = '0;
            pc_nxt = pc_inc;
            if (CW'(pc_inc) >= eff_cnt) begin
              ph_nxt = PH_RESET;
            end
          end else begin
            bc_nxt = bc_r + 1'b1;
          end
        end
        PH_RESET: begin
          ph_nxt = PH_RESET;
          if (rc_r == RC_W'(RESET_SLOTS - 1)) begin
            slot.frame_end = 1'b1;
            ph_nxt = PH_IDLE;
            pc_nxt = '0;
            bc_nxt = '0;
            rc_nxt = '0;
          end else begin
            rc_nxt = rc_r + 1'b1;
          end
        end
        PH_IDLE: begin
          ph_nxt = PH_IDLE;
        end
        default: begin
          ph_nxt = PH_IDLE;
        end
      endcase
      slot.busy = (ph_nxt != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      pc_r <= '0;
      bc_r <= '0;
      rc_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      pc_r <= pc_nxt;
      bc_r <= bc_nxt;
      rc_r <= rc_nxt;
    end
  end

  `WSPS_ASSERT_NOW(a_bit_cursor_range, 1'b1, bc_r <= BW'(wsps_pkg::BITS_PER_PIXEL - 1), "bit cursor out of range")
  `WSPS_ASSERT_NOW(a_idle_cursors_clear, ph_r == PH_IDLE, pc_r == '0 && bc_r == '0 && rc_r == '0, "cursors not cleared while idle")
  `WSPS_ASSERT_NEXT(a_end_goes_idle, acc_tick && slot.frame_end, ph_r == PH_IDLE, "frame end did not return to idle")

endmodule

[src/wsps_out.sv]
`include "ws2812_pixel_serializer_assert.svh"

module wsps_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  wsps_pkg::slot_t                  slot,
  input  logic [wsps_pkg::LOW_DUTY_W-1:0]  low_duty,
  input  logic [wsps_pkg::PIXEL_W-1:0]     rdata,
  output logic                             s1_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wsps_pkg::DUTY_W-1:0]      out_duty,
  output logic                             out_busy,
  output logic                             out_end
);

  localparam int BW = wsps_pkg::BIT_W;

  logic                            s1_valid_r, s1_valid_nxt;
  wsps_pkg::slot_t                 s1_slot_r;
  logic [wsps_pkg::LOW_DUTY_W-1:0] s1_low_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [wsps_pkg::DUTY_W-1:0]     out_duty_r, duty_nxt;
  logic                            out_busy_r, out_end_r;
  logic                            out_adv, s1_adv, cur_bit;
  logic [BW-1:0]                   bit_pos;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign s1_ready = !s1_valid_r || out_adv;

  // Bits leave MSB first, so slot k of a pixel takes bit 23-k.
  assign bit_pos = BW'(wsps_pkg::PIXEL_W - 1) - s1_slot_r.bit_sel;
  assign cur_bit = rdata[bit_pos];

  always_comb begin
    duty_nxt = '0;
    if (s1_slot_r.is_data) begin
      duty_nxt = cur_bit ? {s1_low_r, 1'b0} : {1'b0, s1_low_r};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_slot_r <= slot;
      s1_low_r  <= low_duty;
    end
    if (s1_adv) begin
      out_duty_r <= duty_nxt;
      out_busy_r <= s1_slot_r.busy;
      out_end_r  <= s1_slot_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign out_busy  = out_busy_r;
  assign out_end   = out_end_r;

  `WSPS_ASSERT_NEXT(a_s1_held, s1_valid_r && !out_adv, s1_valid_r, "pending slot dropped under stall")
  `WSPS_ASSERT_NOW(a_end_not_busy, out_valid_r && out_end_r, !out_busy_r, "frame end reported as busy")
  `WSPS_ASSERT_NOW(a_duty_busy, out_valid_r && out_duty_r != '0, out_busy_r, "data slot reported as idle")

endmodule

[src/ws2812_pixel_serializer.sv]
// Channel | Direction | Handshake                 | Contents
// in_     | slave     | in_tvalid / in_tready     | tuser: func; tdata: index and 3 bytes
// out_    | master    | out_tvalid / out_tready   | tdata: duty, busy; tlast: frame end
// cfg_    | APB slave | psel, penable, pready = 1 | led_count at 0x0, low_duty at 0x4
//
// One input word is taken per clock cycle while in_tready is high. A slot tick issues the
// pixel memory's registered read and loads the read stage at its accepting edge; the output
// register takes the result when the output is not stalled and then offers the result word.
// Only slot ticks produce output words; write and show words produce none.
// Reset (rst_n low, synchronous) idles the frame sequencer and empties the output
// pipeline; the pixel memory keeps its contents and needs no clearing pass.
// A stalled output holds one word in the output register and one in the read stage;
// in_tready falls only when both are full.
module ws2812_pixel_serializer #(
  parameter int PIXEL_DEPTH = wsps_pkg::DEF_PIXEL_DEPTH,
  parameter int RESET_SLOTS = wsps_pkg::DEF_RESET_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] pixel_index, [15:8] first_byte, [23:16] second_byte, [31:24] third_byte
  input  logic [31:0]                     in_tdata,
  // [1:0] func
  input  logic [wsps_pkg::FUNC_W-1:0]     in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] duty, [16] busy_res, [23:17] zero
  output logic [23:0]                     out_tdata,
  output logic                            out_tlast,
  // Configuration port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wsps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wsps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wsps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
  localparam int IW = ($clog2(PIXEL_DEPTH + 1) > wsps_pkg::INDEX_W) ?
                      $clog2(PIXEL_DEPTH + 1) : wsps_pkg::INDEX_W;
  localparam int BY = wsps_pkg::BYTE_W;

  logic [wsps_pkg::LED_COUNT_W-1:0] led_count_r, led_count_nxt;
  logic [wsps_pkg::LOW_DUTY_W-1:0]  low_duty_r, low_duty_nxt;
  logic                             cfg_wr, in_acc, acc_write, acc_show, acc_tick;
  logic [wsps_pkg::INDEX_W-1:0]     pixel_index;
  logic [wsps_pkg::PIXEL_W-1:0]     wr_pixel, rdata;
  logic                             wr_en, rd_en, s1_ready, out_busy;
  logic [AW-1:0]                    rd_addr;
  logic [wsps_pkg::DUTY_W-1:0]      out_duty;
  wsps_pkg::slot_t                  slot;

  // Register access. The byte offset bits below bit 2 are not decoded.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    led_count_nxt = led_count_r;
    low_duty_nxt  = low_duty_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        wsps_pkg::REG_LED_COUNT: led_count_nxt = cfg_pwdata[wsps_pkg::LED_COUNT_W-1:0];
        wsps_pkg::REG_LOW_DUTY:  low_duty_nxt  = cfg_pwdata[wsps_pkg::LOW_DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      wsps_pkg::REG_LED_COUNT: cfg_prdata = wsps_pkg::CFG_DATA_W'(led_count_r);
      wsps_pkg::REG_LOW_DUTY:  cfg_prdata = wsps_pkg::CFG_DATA_W'(low_duty_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= wsps_pkg::LED_COUNT_W'(1);
      low_duty_r  <= wsps_pkg::LOW_DUTY_W'(1);
    end else begin
      led_count_r <= led_count_nxt;
      low_duty_r  <= low_duty_nxt;
    end
  end

  // Input decode. The unused func code is accepted and has no effect.
  assign in_tready   = s1_ready;
  assign in_acc      = in_tvalid && in_tready;
  assign acc_write   = in_acc && (in_tuser == wsps_pkg::FUNC_WRITE);
  assign acc_show    = in_acc && (in_tuser == wsps_pkg::FUNC_SHOW);
  assign acc_tick    = in_acc && (in_tuser == wsps_pkg::FUNC_TICK);
  assign pixel_index = in_tdata[BY-1:0];
  assign wr_pixel    = {in_tdata[2*BY-1:BY], in_tdata[3*BY-1:2*BY], in_tdata[4*BY-1:3*BY]};

  // Indexes beyond the memory are dropped.
  assign wr_en = acc_write && (IW'(pixel_index) < IW'(PIXEL_DEPTH));

  // A write and a later tick to the same pixel never overlap: the write lands at
  // its accept edge, and the tick's read is issued at a later edge.
  wsps_ram #(
    .WIDTH (wsps_pkg::PIXEL_W),
    .DEPTH (PIXEL_DEPTH)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(pixel_index)),
    .wdata (wr_pixel),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Frame sequencer: decides each slot and issues the pixel read.
  wsps_ctrl #(
    .PIXEL_DEPTH (PIXEL_DEPTH),
    .RESET_SLOTS (RESET_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_show  (acc_show),
    .acc_tick  (acc_tick),
    .led_count (led_count_r),
    .slot      (slot),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Read stage and output register: picks the bit and forms the compare value.
  wsps_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc_tick),
    .slot      (slot),
    .low_duty  (low_duty_r),
    .rdata     (rdata),
    .s1_ready  (s1_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_duty  (out_duty),
    .out_busy  (out_busy),
    .out_end   (out_tlast)
  );

  assign out_tdata = {7'b0, out_busy, out_duty};

endmodule
